@@ hw/rtl/clamped_linear_parameter_ramp_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clamped linear parameter ramp
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_LINEAR_PARAMETER_RAMP_DEFINES_SVH
`define CLAMPED_LINEAR_PARAMETER_RAMP_DEFINES_SVH

// Same-cycle implication
`define CLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clr: assertion failed");

// Next-cycle implication
`define CLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clr: assertion failed");

`endif

@@ hw/rtl/clr_pkg.sv @@
// ----------------------------------------------------------------------------
// clr_pkg
// Widths, codes and shared types of the clamped linear parameter ramp.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int ValW  = 16;             // signed Q8.8 level
  localparam int TimeW = 32;             // time units
  localparam int FracW = 16;             // unsigned Q0.16 ratio and position
  localparam int CmdW  = 2;
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam int CntW  = $clog2(FracW);
  localparam int ProdW = ValW + FracW + 1;

  localparam logic signed [ValW-1:0] RangeMinRst = 16'sd0;
  localparam logic signed [ValW-1:0] RangeMaxRst = 16'sd25600;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 2'd0,
    CMD_START    = 2'd1,
    CMD_RETARGET = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_RANGE_MIN = 1'b0,
    REG_RANGE_MAX = 1'b1
  } reg_e;

  typedef struct packed {
    logic signed [ValW-1:0] min_v;
    logic signed [ValW-1:0] max_v;
  } range_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

@@ hw/rtl/clr_if.sv @@
// ----------------------------------------------------------------------------
// clr_req_if / clr_rsp_if
// Valid/ready channels carrying ramp commands and ramp reports.
// ----------------------------------------------------------------------------
interface clr_req_if;
  import clr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         cmd;
  logic signed [ValW-1:0]  from_value;
  logic signed [ValW-1:0]  to_value;
  logic [TimeW-1:0]        duration;
  logic signed [ValW-1:0]  current_value;
  logic [TimeW-1:0]        time_delta;

  modport source (
    output valid, cmd, from_value, to_value, duration, current_value, time_delta,
    input  ready
  );
  modport sink (
    input  valid, cmd, from_value, to_value, duration, current_value, time_delta,
    output ready
  );
endinterface

interface clr_rsp_if;
  import clr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ValW-1:0]  ramp_value;
  logic [FracW-1:0]        range_position;

  modport source (output valid, ramp_value, range_position, input ready);
  modport sink (input valid, ramp_value, range_position, output ready);
endinterface

@@ hw/rtl/clr_div.sv @@
// ----------------------------------------------------------------------------
// clr_div
// Bit-serial restoring divider: floor(a * 2^16 / d) for a < d, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module clr_div import clr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] dividend_i,
  input  logic [TimeW-1:0] divisor_i,
  output logic [FracW-1:0] quot_o,
  output seq_stat_t        stat_o
);

  logic [TimeW-1:0] rem_q, rem_d, div_q;
  logic [FracW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [TimeW:0]   shifted, trial;
  logic             fits, last;

  // Shift in one bit and try a subtract
  always_comb begin
    shifted = {rem_q, 1'b0};
    trial   = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
    rem_d   = fits ? trial[TimeW-1:0] : shifted[TimeW-1:0];
    last    = cnt_q == CntW'(FracW - 1);
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FracW-2:0], fits};
    end
  end

  assign quot_o = quot_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

@@ hw/rtl/clr_mul.sv @@
// ----------------------------------------------------------------------------
// clr_mul
// Bit-serial shift-add multiplier: signed span times unsigned Q0.16 ratio,
// multiplier bits taken MSB first.
// ----------------------------------------------------------------------------
module clr_mul import clr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ValW:0]    mcand_i,
  input  logic [FracW-1:0]        mplier_i,
  output logic signed [ProdW-1:0] prod_o,
  output seq_stat_t               stat_o
);

  logic signed [ProdW-1:0] acc_q, acc_d, addend;
  logic signed [ValW:0]    mcand_q;
  logic [FracW-1:0]        mplier_q;
  logic [CntW-1:0]         cnt_q;
  logic                    busy_q, done_q, last;

  // Double the sum and add the span where the ratio bit is set
  always_comb begin
    addend = mplier_q[FracW-1] ? {{(ProdW-ValW-1){mcand_q[ValW]}}, mcand_q} : '0;
    acc_d  = (acc_q <<< 1) + addend;
    last   = cnt_q == CntW'(FracW - 1);
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Accumulator and multiplier shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mplier_q <= {mplier_q[FracW-2:0], 1'b0};
    end
  end

  assign prod_o = acc_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

@@ hw/rtl/clr_cfg.sv @@
// ----------------------------------------------------------------------------
// clr_cfg
// APB register file holding the allowed range of the ramp value.
// ----------------------------------------------------------------------------
module clr_cfg import clr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output range_t           range_o
);

  logic signed [ValW-1:0] min_q, max_q, rd_val;
  logic                   wr_en;
  reg_e                   sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_e'(paddr[2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= RangeMinRst;
      max_q <= RangeMaxRst;
    end else if (wr_en) begin
      unique case (sel)
        REG_RANGE_MIN: min_q <= pwdata[ValW-1:0];
        REG_RANGE_MAX: max_q <= pwdata[ValW-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign extended
  always_comb begin
    unique case (sel)
      REG_RANGE_MIN: rd_val = min_q;
      REG_RANGE_MAX: rd_val = max_q;
      default:       rd_val = min_q;
    endcase
    prdata = {{(DataW-ValW){rd_val[ValW-1]}}, rd_val};
  end

  assign range_o = '{min_v: min_q, max_v: max_q};

endmodule

@@ hw/rtl/clamped_linear_parameter_ramp.sv @@
// ----------------------------------------------------------------------------
// clamped_linear_parameter_ramp
// Timed linear ramp of a Q8.8 control value with range clamp and Q0.16
// position report.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake              Payload
//  req_i     in    valid/ready            cmd, from/to/current value, duration,
//                                         time_delta
//  rsp_o     out   valid/ready            ramp_value, range_position
//  APB       in    psel/penable/pready    range_min @0x0, range_max @0x4
//
//  Start and retarget are applied as they are accepted and leave the block idle.
//  A tick runs up to two passes of the serial divider (ratio, then position)
//  and one pass of the serial multiplier before the next item is taken. A tick
//  at zero length or at the ramp end skips the ratio divide and multiply.
//  The report waits in an output register, so a stalled sink holds only the
//  next tick's final step. Reset clears ramp state and loads the range reset.
// ----------------------------------------------------------------------------
`include "clamped_linear_parameter_ramp_defines.svh"

module clamped_linear_parameter_ramp import clr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  clr_req_if.sink          req_i,
  clr_rsp_if.source        rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EVAL  = 9'b000000010,
    ST_DIV_T = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_CLAMP = 9'b000010000,
    ST_POS   = 9'b000100000,
    ST_CMP   = 9'b001000000,
    ST_DIV_P = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e                  state_q, state_d;
  range_t                  range;
  logic signed [ValW-1:0]  start_q, end_q, value_q, out_value_q;
  logic [TimeW-1:0]        elapsed_q, len_q, elapsed_new;
  logic [TimeW:0]          time_sum;
  logic signed [ValW:0]    num_q, den_q, span;
  logic [ValW:0]           num_mag, den_mag;
  logic signed [ValW+1:0]  lvl;
  logic [FracW-1:0]        pos_q, out_pos_q, div_quot;
  logic                    out_valid_q, out_free, accept;
  logic                    tick_acc, start_acc, retarget_acc, restart;
  logic                    div_start, mul_start, pos_zero, pos_sat;
  logic [TimeW-1:0]        div_a, div_d;
  logic signed [ProdW-1:0] mul_prod;
  seq_stat_t               div_stat, mul_stat;

  clr_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .range_o (range)
  );

  clr_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_d),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  clr_mul u_mul (
    .clk_i, .rst_ni,
    .start_i  (mul_start),
    .mcand_i  (span),
    .mplier_i (div_quot),
    .prod_o   (mul_prod),
    .stat_o   (mul_stat)
  );

  // Decode the accepted command
  assign req_i.ready = state_q == ST_IDLE;
  assign accept      = req_i.valid && req_i.ready;
  always_comb begin
    tick_acc     = 1'b0;
    start_acc    = 1'b0;
    retarget_acc = 1'b0;
    unique case (req_i.cmd)
      CMD_TICK:     tick_acc     = accept;
      CMD_START:    start_acc    = accept;
      CMD_RETARGET: retarget_acc = accept;
      default: ;
    endcase
  end

  // Advance time, saturating at the ramp length
  assign time_sum    = {1'b0, elapsed_q} + {1'b0, req_i.time_delta};
  assign elapsed_new = (time_sum > {1'b0, len_q}) ? len_q : time_sum[TimeW-1:0];

  assign restart = (start_q < req_i.current_value) && (req_i.current_value < end_q)
                   && (elapsed_q < len_q);

  // Span, interpolated level and position magnitudes
  assign span    = {end_q[ValW-1], end_q} - {start_q[ValW-1], start_q};
  assign lvl     = {{2{start_q[ValW-1]}}, start_q}
                   + {mul_prod[ProdW-1], mul_prod[ProdW-1:FracW]};
  assign num_mag = num_q[ValW] ? (~num_q + 1'b1) : num_q;
  assign den_mag = den_q[ValW] ? (~den_q + 1'b1) : den_q;
  assign pos_zero = (den_q == '0) || (num_q == '0) || (num_q[ValW] != den_q[ValW]);
  assign pos_sat  = num_mag >= den_mag;

  // Divider operands: ratio in EVAL, position in CMP
  assign div_a = (state_q == ST_CMP) ? TimeW'(num_mag) : elapsed_q;
  assign div_d = (state_q == ST_CMP) ? TimeW'(den_mag) : len_q;

  assign out_free = !out_valid_q || rsp_o.ready;

  // Next state and unit launches
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mul_start = 1'b0;
    unique case (state_q)
      ST_IDLE:  if (tick_acc) state_d = ST_EVAL;
      ST_EVAL: begin
        if (len_q == '0 || elapsed_q == len_q) begin
          state_d = ST_POS;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_T;
        end
      end
      ST_DIV_T: begin
        if (div_stat.done) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL:   if (mul_stat.done) state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_POS;
      ST_POS:   state_d = ST_CMP;
      ST_CMP: begin
        if (pos_zero || pos_sat) begin
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_P;
        end
      end
      ST_DIV_P: if (div_stat.done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control and ramp state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      start_q     <= '0;
      end_q       <= '0;
      elapsed_q   <= '0;
      len_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (start_acc) begin
        start_q   <= req_i.from_value;
        end_q     <= req_i.to_value;
        len_q     <= req_i.duration;
        elapsed_q <= '0;
      end else if (retarget_acc) begin
        if (restart) begin
          start_q   <= req_i.current_value;
          len_q     <= len_q - elapsed_q;
          elapsed_q <= '0;
        end else begin
          end_q <= req_i.current_value;
        end
      end else if (tick_acc) begin
        elapsed_q <= elapsed_new;
      end
    end
  end

  // Value, position and output registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_EVAL:  value_q <= (len_q == '0) ? start_q : end_q;
      ST_MUL:   if (mul_stat.done) value_q <= lvl[ValW-1:0];
      ST_CLAMP: begin
        if (value_q > range.max_v) begin
          value_q <= range.max_v;
        end else if (value_q < range.min_v) begin
          value_q <= range.min_v;
        end
      end
      ST_POS: begin
        num_q <= {value_q[ValW-1], value_q} - {range.min_v[ValW-1], range.min_v};
        den_q <= {range.max_v[ValW-1], range.max_v} - {range.min_v[ValW-1], range.min_v};
      end
      ST_CMP: begin
        if (pos_zero) begin
          pos_q <= '0;
        end else if (pos_sat) begin
          pos_q <= '1;
        end
      end
      ST_DIV_P: if (div_stat.done) pos_q <= div_quot;
      ST_OUT: begin
        if (out_free) begin
          out_value_q <= value_q;
          out_pos_q   <= pos_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.ramp_value     = out_value_q;
  assign rsp_o.range_position = out_pos_q;

  // Checks
  `CLR_ASSERT_IMP(a_elapsed_in_len, 1'b1, elapsed_q <= len_q)
  `CLR_ASSERT_IMP(a_idle_units_free, req_i.ready, !div_stat.busy && !mul_stat.busy)
  `CLR_ASSERT_IMP(a_units_exclusive, div_stat.busy, !mul_stat.busy)
  `CLR_ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && out_free, rsp_o.valid)

endmodule
